// ----- sv/atrp_pkg.sv -----
// Types and constants shared by the ATR parser modules.
`default_nettype none
package atrp_pkg;

  localparam int unsigned MAX_ANSWER_BYTES = 33;
  localparam int unsigned MAX_GROUPS       = 8;

  localparam logic [2:0] PHASE_IDLE   = 3'd0;
  localparam logic [2:0] PHASE_FORMAT = 3'd1;
  localparam logic [2:0] PHASE_IFACE  = 3'd2;
  localparam logic [2:0] PHASE_HIST   = 3'd3;
  localparam logic [2:0] PHASE_CHECK  = 3'd4;

  localparam logic [3:0] PRESENCE_TD = 4'h8;

  localparam logic [1:0] FAULT_NONE     = 2'd0;
  localparam logic [1:0] FAULT_TOO_LONG = 2'd1;
  localparam logic [1:0] FAULT_CHAIN    = 2'd2;
  localparam logic [1:0] FAULT_OUTSIDE  = 2'd3;

  localparam logic [5:0] MAX_BYTES_C  = 6'(MAX_ANSWER_BYTES);
  localparam logic [3:0] MAX_GROUPS_C = 4'(MAX_GROUPS);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_answer;
  } atrp_in_t;

  typedef struct packed {
    logic       complete;
    logic [1:0] fault;
    logic [3:0] offered_protocol;
    logic [5:0] answer_length;
    logic       check_byte_present;
    logic [3:0] historical_count;
  } atrp_out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] presence;
    logic [3:0] groups;
    logic [3:0] hist_left;
    logic [3:0] hist_total;
    logic [5:0] byte_cnt;
    logic [3:0] protocol;
    logic       need_check;
  } atrp_state_t;

  localparam atrp_state_t STATE_RESET = '{
    phase:      PHASE_IDLE,
    presence:   4'd0,
    groups:     4'd0,
    hist_left:  4'd0,
    hist_total: 4'd0,
    byte_cnt:   6'd0,
    protocol:   4'd0,
    need_check: 1'b0
  };

endpackage
`default_nettype wire

// ----- sv/atrp_step.sv -----
// Per-byte ATR parse logic: next state and status item from one byte.
`default_nettype none
module atrp_step (
  input  wire atrp_pkg::atrp_in_t    item,
  input  wire atrp_pkg::atrp_state_t state,
  output atrp_pkg::atrp_state_t      state_nxt,
  output atrp_pkg::atrp_out_t        result
);
  import atrp_pkg::*;

  atrp_state_t s;
  logic [3:0]  lowest;
  logic        done;
  logic [1:0]  fault;
  logic        emit_state;
  logic        chain_fault;

  always_comb begin
    s           = state;
    done        = 1'b0;
    fault       = FAULT_NONE;
    emit_state  = 1'b1;
    chain_fault = 1'b0;
    lowest      = state.presence & (4'd0 - state.presence);

    if (item.start_of_answer) begin
      s          = STATE_RESET;
      s.byte_cnt = 6'd1;
      s.phase    = PHASE_FORMAT;
    end else if (state.phase < PHASE_FORMAT || state.phase > PHASE_CHECK) begin
      s.phase    = PHASE_IDLE;
      fault      = FAULT_OUTSIDE;
      emit_state = 1'b0;
    end else if (state.byte_cnt >= MAX_BYTES_C) begin
      s.phase = PHASE_IDLE;
      fault   = FAULT_TOO_LONG;
    end else begin
      s.byte_cnt = state.byte_cnt + 6'd1;
      unique case (state.phase)
        PHASE_FORMAT: begin
          s.presence   = item.data_byte[7:4];
          s.hist_total = item.data_byte[3:0];
          s.hist_left  = item.data_byte[3:0];
        end
        PHASE_IFACE: begin
          s.presence = state.presence & ~lowest;
          if (lowest == PRESENCE_TD) begin
            s.groups   = state.groups + 4'd1;
            s.protocol = item.data_byte[3:0];
            if (item.data_byte[3:0] != 4'd0) begin
              s.need_check = 1'b1;
            end
            if (item.data_byte[7] && s.groups >= MAX_GROUPS_C) begin
              chain_fault = 1'b1;
            end else begin
              s.presence = item.data_byte[7:4];
            end
          end
        end
        PHASE_HIST: begin
          s.hist_left = state.hist_left - 4'd1;
        end
        default: ;
      endcase

      if (chain_fault) begin
        fault   = FAULT_CHAIN;
        s.phase = PHASE_IDLE;
      end else if (state.phase == PHASE_CHECK) begin
        s.phase = PHASE_IDLE;
        done    = 1'b1;
      end else if (s.presence != 4'd0) begin
        s.phase = PHASE_IFACE;
      end else if (s.hist_left != 4'd0) begin
        s.phase = PHASE_HIST;
      end else if (s.need_check) begin
        s.phase = PHASE_CHECK;
      end else begin
        s.phase = PHASE_IDLE;
        done    = 1'b1;
      end
    end

    state_nxt                 = s;
    result.complete           = done;
    result.fault              = fault;
    result.offered_protocol   = emit_state ? s.protocol   : 4'd0;
    result.answer_length      = emit_state ? s.byte_cnt   : 6'd0;
    result.check_byte_present = emit_state ? s.need_check : 1'b0;
    result.historical_count   = emit_state ? s.hist_total : 4'd0;
  end

endmodule
`default_nettype wire

// ----- sv/smart_card_atr_parser_unit.sv -----
// ATR parser top level: input register, per-byte parse logic, result register.
// Path: input register, then result register, which drives out_valid and out_item.
// Throughput: one byte per cycle unless out_ready stalls the output; the parse state
// updates as a byte moves from the input register into the result register.
// Reset (rst_n low, synchronous): pipeline empty, parser idle awaiting TS.
`default_nettype none
module smart_card_atr_parser_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire atrp_pkg::atrp_in_t in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output atrp_pkg::atrp_out_t out_item
);
  import atrp_pkg::*;

  logic        in_vld_r;
  atrp_in_t    in_item_r;
  logic        out_vld_r;
  atrp_out_t   out_item_r;
  atrp_state_t state_r;
  atrp_state_t state_nxt;
  atrp_out_t   result;
  logic        out_free;

  atrp_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .state_nxt (state_nxt),
    .result    (result)
  );

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || out_free;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= STATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (out_free && in_vld_r) begin
      out_item_r <= result;
    end
  end

endmodule
`default_nettype wire
